@@ hdl/ialu_pkg.sv @@
// Shared types and constants for the integer ALU instruction executor.
`timescale 1ns / 1ps
`default_nettype none
package ialu_pkg;

    localparam int XLEN_DEF  = 64;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OPC   = 2'd1;
    localparam logic [1:0] ST_BAD_FUNCT = 2'd2;

    localparam logic [6:0] OPC_REG = 7'b0110011;
    localparam logic [6:0] OPC_IMM = 7'b0010011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_SLL = 3'b001;
    localparam logic [2:0] F3_SLT = 3'b010;
    localparam logic [2:0] F3_SRL = 3'b101;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] dest;
        logic [1:0]        status;
    } alu_ctl_t;

endpackage
`default_nettype wire

@@ hdl/ialu_chan_if.sv @@
// Valid/ready channel interfaces for command and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ialu_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        instruction;
    logic [4:0]         reg_index;
    logic signed [31:0] write_value;

    modport source (output valid, kind, instruction, reg_index, write_value, input ready);
    modport sink (input valid, kind, instruction, reg_index, write_value, output ready);
endinterface

interface ialu_res_if;
    logic               valid;
    logic               ready;
    logic [4:0]         dest_index;
    logic signed [63:0] result_value;
    logic [1:0]         status;

    modport source (output valid, dest_index, result_value, status, input ready);
    modport sink (input valid, dest_index, result_value, status, output ready);
endinterface
`default_nettype wire

@@ hdl/ialu_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ialu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/ialu_alu.sv @@
// Instruction decode and ALU: computes the destination, value and status of one item.
`timescale 1ns / 1ps
`default_nettype none
module ialu_alu #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input  wire logic [1:0]                kind,
    input  wire logic [31:0]               instruction,
    input  wire logic [ialu_pkg::REG_AW-1:0] reg_index,
    input  wire logic [31:0]               write_value,
    input  wire logic [XLEN-1:0]           a,
    input  wire logic [XLEN-1:0]           b,
    output ialu_pkg::alu_ctl_t             ctl,
    output logic      [XLEN-1:0]           value
);
    import ialu_pkg::*;

    localparam logic [6:0] XLEN_W = 7'(XLEN);

    logic [6:0]        opc;
    logic [REG_AW-1:0] rd;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [11:0]       imm12;
    logic [XLEN-1:0]   imm;
    logic [5:0]        sh_imm;
    logic [5:0]        sh_reg;
    logic [XLEN-1:0]   wv_x;
    logic [XLEN-1:0]   r;
    logic [REG_AW-1:0] dest;
    logic [1:0]        status;

    assign opc    = instruction[6:0];
    assign rd     = instruction[11:7];
    assign f3     = instruction[14:12];
    assign f7     = instruction[31:25];
    assign imm12  = instruction[31:20];
    assign imm    = XLEN'($signed(imm12));
    assign sh_imm = imm12[5:0];
    assign sh_reg = b[5:0];
    assign wv_x   = XLEN'($signed(write_value));

    always_comb
    begin
        status = ST_OK;
        r      = '0;
        dest   = '0;
        case (kind)
            KIND_EXEC:
            begin
                dest = rd;
                case (opc)
                    OPC_REG:
                    begin
                        if (f7 == F7_ALT)
                        begin
                            if (f3 != F3_ADD)
                                status = ST_BAD_FUNCT;
                            else
                                r = a - b;
                        end
                        else if (f7 != F7_BASE)
                        begin
                            status = ST_BAD_FUNCT;
                        end
                        else
                        begin
                            case (f3)
                                F3_ADD: r = a + b;
                                F3_OR:  r = a | b;
                                F3_AND: r = a & b;
                                F3_SLL: r = ({1'b0, sh_reg} >= XLEN_W) ? '0 : (a << sh_reg);
                                F3_SRL: r = ({1'b0, sh_reg} >= XLEN_W) ? '0 : (a >> sh_reg);
                                default: status = ST_BAD_FUNCT;
                            endcase
                        end
                    end
                    OPC_IMM:
                    begin
                        case (f3)
                            F3_ADD: r = a + imm;
                            F3_SLT: r = XLEN'($signed(a) < $signed(imm));
                            F3_OR:  r = a | imm;
                            F3_AND: r = a & imm;
                            F3_SLL, F3_SRL:
                            begin
                                if ((imm12[11:6] != 6'd0) || ({1'b0, sh_imm} >= XLEN_W))
                                    status = ST_BAD_FUNCT;
                                else if (f3 == F3_SLL)
                                    r = a << sh_imm;
                                else
                                    r = a >> sh_imm;
                            end
                            default: status = ST_BAD_FUNCT;
                        endcase
                    end
                    default: status = ST_BAD_OPC;
                endcase
            end
            KIND_WRITE:
            begin
                dest = reg_index;
                r    = wv_x;
            end
            KIND_READ:
            begin
                dest = reg_index;
                r    = a;
            end
            default: status = ST_BAD_OPC;
        endcase
    end

    always_comb
    begin
        ctl.status = status;
        ctl.dest   = (status == ST_OK) ? dest : '0;
        ctl.we     = (status == ST_OK) && (dest != '0)
                     && ((kind == KIND_EXEC) || (kind == KIND_WRITE));
        value      = ((status == ST_OK) && (dest != '0)) ? r : '0;
    end

endmodule
`default_nettype wire

@@ hdl/integer_alu_instruction_executor.sv @@
// Top level: register file in two RAM copies, operand stage, ALU and result register.
//
// One item is accepted every cycle unless a held result stalls the operand stage.
// When an item is accepted its operand registers are read from two copies of the
// 32-entry register file (one synchronous read port each); while the item is in
// the operand stage the ALU computes the result, and when the stage advances it
// writes the register file and loads the result register, from which the result
// is offered. A write made in the same cycle as a following item's read is
// forwarded to that item. After reset all registers read as zero through a
// per-entry valid bit, so no clearing pass is needed; x0 is never written.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_instruction_executor #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ialu_cmd_if.sink   cmd,
    ialu_res_if.source res
);
    import ialu_pkg::*;

    logic              accept;
    logic              s1_adv;
    logic [REG_AW-1:0] raddr_a;
    logic [REG_AW-1:0] raddr_b;
    logic [XLEN-1:0]   q_a;
    logic [XLEN-1:0]   q_b;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    alu_ctl_t          ctl;
    logic [XLEN-1:0]   alu_value;
    logic              wr_en;

    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_kind_reg;
    logic [31:0]          s1_instr_reg;
    logic [REG_AW-1:0]    s1_idx_reg;
    logic [31:0]          s1_wv_reg;
    logic [REG_AW-1:0]    s1_addr_a_reg;
    logic [REG_AW-1:0]    s1_addr_b_reg;
    logic                 s1_vld_a_reg;
    logic                 s1_vld_b_reg;
    logic                 fwd_en_reg;
    logic [REG_AW-1:0]    fwd_addr_reg;
    logic [XLEN-1:0]      fwd_data_reg;
    logic [REG_COUNT-1:0] vld_reg, vld_next;
    logic                 out_valid_reg, out_valid_next;
    logic [REG_AW-1:0]    out_dest_reg;
    logic [63:0]          out_value_reg;
    logic [1:0]           out_status_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign accept    = cmd.valid && cmd.ready;
    assign raddr_a   = (cmd.kind == KIND_EXEC) ? cmd.instruction[19:15] : cmd.reg_index;
    assign raddr_b   = cmd.instruction[24:20];
    assign wr_en     = s1_adv && ctl.we;

    ialu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ctl.dest),
        .wdata (alu_value),
        .re    (accept),
        .raddr (raddr_a),
        .rdata (q_a)
    );

    ialu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ctl.dest),
        .wdata (alu_value),
        .re    (accept),
        .raddr (raddr_b),
        .rdata (q_b)
    );

    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == s1_addr_a_reg))
            op_a = fwd_data_reg;
        else
            op_a = s1_vld_a_reg ? q_a : '0;
        if (fwd_en_reg && (fwd_addr_reg == s1_addr_b_reg))
            op_b = fwd_data_reg;
        else
            op_b = s1_vld_b_reg ? q_b : '0;
    end

    ialu_alu #(.XLEN(XLEN)) u_alu (
        .kind        (s1_kind_reg),
        .instruction (s1_instr_reg),
        .reg_index   (s1_idx_reg),
        .write_value (s1_wv_reg),
        .a           (op_a),
        .b           (op_b),
        .ctl         (ctl),
        .value       (alu_value)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
        vld_next = vld_reg;
        if (wr_en)
            vld_next[ctl.dest] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            fwd_en_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            if (accept)
                fwd_en_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= cmd.kind;
            s1_instr_reg  <= cmd.instruction;
            s1_idx_reg    <= cmd.reg_index;
            s1_wv_reg     <= cmd.write_value;
            s1_addr_a_reg <= raddr_a;
            s1_addr_b_reg <= raddr_b;
            s1_vld_a_reg  <= vld_reg[raddr_a];
            s1_vld_b_reg  <= vld_reg[raddr_b];
            fwd_addr_reg  <= ctl.dest;
            fwd_data_reg  <= alu_value;
        end
        if (s1_adv)
        begin
            out_dest_reg   <= ctl.dest;
            out_value_reg  <= 64'($signed(alu_value));
            out_status_reg <= ctl.status;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.dest_index   = out_dest_reg;
    assign res.result_value = out_value_reg;
    assign res.status       = out_status_reg;

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (ctl.dest != '0))
        else $error("register x0 written");

    a_x0_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0])
        else $error("x0 valid bit set");

    a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result lost on stage advance");

    a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK))
        |-> ((out_dest_reg == '0) && (out_value_reg == '0)))
        else $error("flagged result carries nonzero fields");

endmodule
`default_nettype wire

@@ sim/integer_alu_instruction_executor_test.sv @@
// Self-checking testbench for the integer ALU instruction executor.
`timescale 1ns / 1ps
module integer_alu_instruction_executor_test;
    import ialu_pkg::*;

    localparam int XLEN = XLEN_DEF;

    localparam logic [1:0] KIND_BAD    = 2'd3;
    localparam logic [2:0] F3_SLTU     = 3'b011;
    localparam logic [2:0] F3_XOR      = 3'b100;
    localparam logic [6:0] F7_MULDIV   = 7'b0000001;
    localparam logic [6:0] OPC_LUI     = 7'b0110111;
    localparam int         HOLD_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] instruction;
        logic [4:0]  reg_index;
        logic [31:0] write_value;
    } alu_cmd_t;

    typedef struct packed {
        logic [4:0]  dest;
        logic [63:0] value;
        logic [1:0]  status;
    } writeback_t;

    class alu_shadow;
        logic [XLEN-1:0] regs [REG_COUNT];
        writeback_t      expected_writebacks [$];
        int              failures;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            failures = 0;
        endfunction

        function void put_reg(logic [4:0] idx, logic [XLEN-1:0] v);
            if (idx != 0)
                regs[idx] = v;
        endfunction

        function void predict_item(alu_cmd_t c);
            logic [6:0]      opc;
            logic [6:0]      f7;
            logic [4:0]      rd;
            logic [4:0]      rs1;
            logic [4:0]      rs2;
            logic [2:0]      f3;
            logic [11:0]     imm12;
            logic [5:0]      sh;
            logic [XLEN-1:0] a;
            logic [XLEN-1:0] b;
            logic [XLEN-1:0] imm;
            logic [XLEN-1:0] r;
            logic [1:0]      st;
            logic [4:0]      dest;
            writeback_t      wb;
            opc   = c.instruction[6:0];
            rd    = c.instruction[11:7];
            f3    = c.instruction[14:12];
            rs1   = c.instruction[19:15];
            rs2   = c.instruction[24:20];
            f7    = c.instruction[31:25];
            imm12 = c.instruction[31:20];
            sh    = imm12[5:0];
            a     = regs[rs1];
            b     = regs[rs2];
            imm   = XLEN'(signed'(imm12));
            r     = '0;
            st    = ST_OK;
            dest  = c.reg_index;
            case (c.kind)
                KIND_EXEC:
                begin
                    dest = rd;
                    if (opc == OPC_REG)
                    begin
                        if (f7 == F7_ALT)
                        begin
                            if (f3 == F3_ADD)
                                r = a - b;
                            else
                                st = ST_BAD_FUNCT;
                        end
                        else if (f7 != F7_BASE)
                            st = ST_BAD_FUNCT;
                        else
                        begin
                            case (f3)
                                F3_ADD: r = a + b;
                                F3_OR:  r = a | b;
                                F3_AND: r = a & b;
                                F3_SLL: r = (b[5:0] >= XLEN) ? '0 : a << b[5:0];
                                F3_SRL: r = (b[5:0] >= XLEN) ? '0 : a >> b[5:0];
                                default: st = ST_BAD_FUNCT;
                            endcase
                        end
                    end
                    else if (opc == OPC_IMM)
                    begin
                        case (f3)
                            F3_ADD: r = a + imm;
                            F3_SLT: r = ($signed(a) < $signed(imm)) ? XLEN'(1) : '0;
                            F3_OR:  r = a | imm;
                            F3_AND: r = a & imm;
                            F3_SLL, F3_SRL:
                            begin
                                if (imm12[11:6] != 0 || sh >= XLEN)
                                    st = ST_BAD_FUNCT;
                                else
                                    r = (f3 == F3_SLL) ? a << sh : a >> sh;
                            end
                            default: st = ST_BAD_FUNCT;
                        endcase
                    end
                    else
                        st = ST_BAD_OPC;
                    if (st == ST_OK)
                        put_reg(rd, r);
                end
                KIND_WRITE: put_reg(c.reg_index, XLEN'(signed'(c.write_value)));
                KIND_READ: ;
                default: st = ST_BAD_OPC;
            endcase
            wb.status = st;
            wb.dest   = (st == ST_OK) ? dest : '0;
            wb.value  = (st == ST_OK) ? 64'(signed'(regs[dest])) : '0;
            expected_writebacks.push_back(wb);
        endfunction

        function void compare_writeback(logic [4:0] d, logic [63:0] v, logic [1:0] s);
            writeback_t wb;
            if (expected_writebacks.size() == 0)
            begin
                if (failures < 10)
                    $display("%0t: unexpected item dest=%0d value=%h status=%0d",
                             $realtime, d, v, s);
                failures++;
            end
            else
            begin
                wb = expected_writebacks.pop_front();
                if (d !== wb.dest || v !== wb.value || s !== wb.status)
                begin
                    if (failures < 10)
                    begin
                        $display("%0t: mismatch exp dest=%0d value=%h status=%0d",
                                 $realtime, wb.dest, wb.value, wb.status);
                        $display("    got dest=%0d value=%h status=%0d", d, v, s);
                    end
                    failures++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   hold_requests;
    int   holds_served;
    int   hold_left;

    alu_shadow shadow;

    ialu_cmd_if cmd_ch ();
    ialu_res_if res_ch ();

    integer_alu_instruction_executor #(
        .XLEN(XLEN)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                shadow.predict_item('{cmd_ch.kind, cmd_ch.instruction, cmd_ch.reg_index,
                                      cmd_ch.write_value});
            if (res_ch.valid && res_ch.ready)
                shadow.compare_writeback(res_ch.dest_index, res_ch.result_value,
                                         res_ch.status);
        end
    end

    // result side: random backpressure plus long holds on request
    initial
    begin
        res_ch.ready = 1'b0;
        holds_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] r_word(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                           logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_REG};
    endfunction

    function automatic logic [31:0] i_word(logic [11:0] imm, logic [2:0] f3, logic [4:0] rd,
                                           logic [4:0] rs1);
        return {imm, rs1, f3, rd, OPC_IMM};
    endfunction

    function automatic alu_cmd_t cmd_exec(logic [31:0] w);
        alu_cmd_t c;
        c.kind        = KIND_EXEC;
        c.instruction = w;
        c.reg_index   = 5'($urandom);
        c.write_value = $urandom;
        return c;
    endfunction

    function automatic alu_cmd_t cmd_write(logic [4:0] idx, logic [31:0] v);
        alu_cmd_t c;
        c = cmd_exec($urandom);
        c.kind        = KIND_WRITE;
        c.reg_index   = idx;
        c.write_value = v;
        return c;
    endfunction

    function automatic alu_cmd_t cmd_read(logic [4:0] idx);
        alu_cmd_t c;
        c = cmd_exec($urandom);
        c.kind      = KIND_READ;
        c.reg_index = idx;
        return c;
    endfunction

    // low registers half the time so results feed later operands often
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic alu_cmd_t random_item();
        alu_cmd_t    c;
        logic [31:0] v;
        logic [11:0] imm;
        logic [2:0]  f3;
        int          pick;
        int          sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 5);
        if (pick < 18)
        begin
            case ($urandom_range(0, 5))
                0: v = 32'h7fffffff;
                1: v = 32'h80000000;
                2: v = 32'hffffffff;
                3: v = $urandom_range(0, 63);
                default: v = $urandom;
            endcase
            c = cmd_write(pick_reg(), v);
        end
        else if (pick < 28)
            c = cmd_read(pick_reg());
        else if (pick < 55)
        begin
            case (sel)
                0, 1: f3 = F3_ADD;
                2: f3 = F3_OR;
                3: f3 = F3_AND;
                4: f3 = F3_SLL;
                default: f3 = F3_SRL;
            endcase
            c = cmd_exec(r_word((sel == 1) ? F7_ALT : F7_BASE, f3, pick_reg(), pick_reg(),
                                pick_reg()));
        end
        else if (pick < 85)
        begin
            imm = 12'($urandom);
            case (sel)
                0: f3 = F3_ADD;
                1: f3 = F3_SLT;
                2: f3 = F3_OR;
                3: f3 = F3_AND;
                4: f3 = F3_SLL;
                default: f3 = F3_SRL;
            endcase
            if (sel >= 4)
                imm = {6'b0, imm[5:0]};
            c = cmd_exec(i_word(imm, f3, pick_reg(), pick_reg()));
        end
        else if (pick < 95)
        begin
            case (sel)
                0, 1: c = cmd_exec(r_word(7'($urandom), 3'($urandom), pick_reg(), pick_reg(),
                                          pick_reg()));
                2: c = cmd_exec(r_word(F7_ALT, 3'($urandom), pick_reg(), pick_reg(),
                                       pick_reg()));
                3: c = cmd_exec(i_word(12'($urandom), ($urandom_range(0, 1) == 0) ? F3_SLTU
                                       : F3_XOR, pick_reg(), pick_reg()));
                default: c = cmd_exec(i_word(12'($urandom), (sel == 4) ? F3_SLL : F3_SRL,
                                             pick_reg(), pick_reg()));
            endcase
        end
        else
        begin
            c = cmd_exec($urandom);
            c.kind = 2'($urandom);
        end
        return c;
    endfunction

    task automatic offer(alu_cmd_t c);
        while (!steady && $urandom_range(0, 99) < 12)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= c.kind;
        cmd_ch.instruction <= c.instruction;
        cmd_ch.reg_index   <= c.reg_index;
        cmd_ch.write_value <= c.write_value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (shadow.expected_writebacks.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        alu_cmd_t c;
        rst_n = 1'b0;
        steady = 1'b0;
        hold_requests = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = KIND_EXEC;
        cmd_ch.instruction = '0;
        cmd_ch.reg_index = '0;
        cmd_ch.write_value = '0;
        shadow = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(cmd_read(5'd5));
        offer(cmd_write(5'd1, 32'h7fffffff));
        offer(cmd_write(5'd2, 32'h80000000));
        offer(cmd_write(5'd3, 32'hffffffff));
        offer(cmd_write(5'd0, 32'd123));
        offer(cmd_read(5'd31));
        offer(cmd_exec(r_word(F7_BASE, F3_ADD, 5'd4, 5'd1, 5'd1)));
        offer(cmd_exec(r_word(F7_ALT, F3_ADD, 5'd5, 5'd2, 5'd1)));
        offer(cmd_exec(r_word(F7_BASE, F3_OR, 5'd6, 5'd1, 5'd2)));
        offer(cmd_exec(r_word(F7_BASE, F3_AND, 5'd7, 5'd3, 5'd1)));
        offer(cmd_exec(r_word(F7_BASE, F3_SLL, 5'd8, 5'd3, 5'd1)));
        offer(cmd_exec(r_word(F7_BASE, F3_SRL, 5'd9, 5'd3, 5'd1)));
        offer(cmd_exec(i_word(12'h7ff, F3_ADD, 5'd10, 5'd1)));
        offer(cmd_exec(i_word(12'h800, F3_ADD, 5'd10, 5'd10)));
        offer(cmd_exec(i_word(12'hfff, F3_SLT, 5'd11, 5'd2)));
        offer(cmd_exec(i_word(12'h800, F3_SLT, 5'd12, 5'd1)));
        offer(cmd_exec(i_word(12'hfff, F3_OR, 5'd13, 5'd0)));
        offer(cmd_exec(i_word(12'h800, F3_AND, 5'd14, 5'd3)));
        offer(cmd_exec(i_word(12'd63, F3_SLL, 5'd15, 5'd3)));
        offer(cmd_exec(i_word(12'd63, F3_SRL, 5'd16, 5'd3)));
        // arithmetic right shift encoding is not supported
        offer(cmd_exec(i_word(12'h401, F3_SRL, 5'd17, 5'd3)));
        offer(cmd_exec(r_word(F7_MULDIV, F3_ADD, 5'd18, 5'd1, 5'd2)));
        offer(cmd_exec(r_word(F7_ALT, F3_OR, 5'd18, 5'd1, 5'd2)));
        offer(cmd_exec(r_word(F7_BASE, F3_SLT, 5'd18, 5'd1, 5'd2)));
        offer(cmd_exec(i_word(12'h0, F3_XOR, 5'd18, 5'd1)));
        offer(cmd_exec({25'($urandom), OPC_LUI}));
        c = cmd_exec($urandom);
        c.kind = KIND_BAD;
        offer(c);
        offer(cmd_exec(r_word(F7_BASE, F3_ADD, 5'd0, 5'd1, 5'd3)));
        drain();

        for (int n = 0; n < 900; n++)
        begin
            steady = (n >= 400 && n < 550);
            if (n == 200 || n == 700)
                hold_requests++;
            if (n == 600)
                drain();
            offer(random_item());
        end
        drain();
        repeat (8) @(posedge clk);

        if (shadow.failures == 0 && shadow.expected_writebacks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ files.f @@
hdl/ialu_pkg.sv
hdl/ialu_chan_if.sv
hdl/ialu_ram.sv
hdl/ialu_alu.sv
hdl/integer_alu_instruction_executor.sv
sim/integer_alu_instruction_executor_test.sv
